/* sv/ethernet_frame_receive_filter_top_defines.svh */
`ifndef ETHERNET_FRAME_RECEIVE_FILTER_TOP_DEFINES_SVH
`define ETHERNET_FRAME_RECEIVE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define EFRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("efrf assertion failed");

// Next-cycle implication.
`define EFRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("efrf assertion failed");

`endif

/* sv/efrf_pkg.sv */
package efrf_pkg;

  localparam int unsigned HEADER_BYTES  = 14;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned FIFO_DEPTH    = 2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [7:0]  BYTE_ONES = 8'hFF;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_ADDR   = 2'd1,
    VERDICT_CRC    = 2'd2,
    VERDICT_SHORT  = 2'd3
  } verdict_e;

  // Per-byte record from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       crc_en;     // byte leaving the tail window lies past the header
    logic       short_frm;  // valid with last
    logic       bcast;      // valid with last
    logic       local_hit;  // valid with last
  } byte_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/efrf_front.sv */
module efrf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [47:0]         station_address_i,
  input  logic                push_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                end_of_frame_i,
  output efrf_pkg::byte_rec_t rec_o
);
  import efrf_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [POSITION_BITS-1:0] POS_CRC  = POSITION_BITS'(HEADER_BYTES + 4);
  localparam logic [POSITION_BITS-1:0] POS_LAST = POSITION_BITS'(HEADER_BYTES + 3);
  localparam logic [POSITION_BITS-1:0] POS_DEST = POSITION_BITS'(6);
  localparam logic [POSITION_BITS-1:0] POS_FULL = POSITION_BITS'(5);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic bcast_q, bcast_d, local_q, local_d;
  logic in_dest;
  logic [7:0] mine;

  assign in_dest = pos_q < POS_DEST;

  always_comb begin
    case (pos_q[2:0])
      3'd0:    mine = station_address_i[47:40];
      3'd1:    mine = station_address_i[39:32];
      3'd2:    mine = station_address_i[31:24];
      3'd3:    mine = station_address_i[23:16];
      3'd4:    mine = station_address_i[15:8];
      default: mine = station_address_i[7:0];
    endcase
  end

  always_comb begin
    bcast_d = bcast_q;
    local_d = local_q;
    if (in_dest) begin
      if (frame_byte_i != BYTE_ONES) bcast_d = 1'b0;
      if (frame_byte_i != mine)      local_d = 1'b0;
    end
    rec_o.data      = frame_byte_i;
    rec_o.last      = end_of_frame_i;
    rec_o.crc_en    = pos_q >= POS_CRC;
    rec_o.short_frm = pos_q < POS_LAST;
    rec_o.bcast     = bcast_d && (pos_q >= POS_FULL);
    rec_o.local_hit = local_d && (pos_q >= POS_FULL);
    pos_d = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bcast_q <= 1'b1;
      local_q <= 1'b1;
    end else if (push_i) begin
      if (end_of_frame_i) begin
        pos_q   <= '0;
        bcast_q <= 1'b1;
        local_q <= 1'b1;
      end else begin
        pos_q   <= pos_d;
        bcast_q <= bcast_d;
        local_q <= local_d;
      end
    end
  end

endmodule

/* sv/efrf_fifo.sv */
module efrf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  efrf_pkg::byte_rec_t  wdata_i,
  input  logic                 pop_i,
  output efrf_pkg::byte_rec_t  rdata_o,
  output efrf_pkg::fifo_stat_t stat_o
);
  import efrf_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH);
  localparam logic [PTR_BITS:0] CNT_FULL = (PTR_BITS+1)'(FIFO_DEPTH);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FIFO_DEPTH - 1);

  byte_rec_t slot_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [PTR_BITS:0]   cnt_q;

  assign stat_o.full  = cnt_q == CNT_FULL;
  assign stat_o.empty = cnt_q == '0;
  assign rdata_o      = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/efrf_back.sv */
module efrf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  efrf_pkg::byte_rec_t rec_i,
  output logic                rec_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_data_o
);
  import efrf_pkg::*;

  logic [7:0]  tail_q [4];
  logic [31:0] crc_q, crc_d;
  logic [31:0] got;
  logic        take, out_valid_q;
  logic [7:0]  out_data_q;
  verdict_e    verdict;

  assign rec_ready_o = !rec_i.last || !out_valid_q || out_ready_i;
  assign take        = rec_valid_i && rec_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign crc_d = rec_i.crc_en ? crc_byte(crc_q, tail_q[0]) : crc_q;
  assign got   = {rec_i.data, tail_q[3], tail_q[2], tail_q[1]};

  always_comb begin
    if (rec_i.short_frm)                         verdict = VERDICT_SHORT;
    else if (!rec_i.bcast && !rec_i.local_hit)   verdict = VERDICT_ADDR;
    else if (got != (crc_d ^ CRC_ONES))          verdict = VERDICT_CRC;
    else                                         verdict = VERDICT_ACCEPT;
  end

  always_ff @(posedge clk_i) begin
    if (take && rec_i.last) begin
      out_data_q <= {4'd0, rec_i.bcast, verdict, verdict == VERDICT_ACCEPT};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= CRC_ONES;
      for (int i = 0; i < 4; i++) tail_q[i] <= '0;
    end else begin
      if (take && rec_i.last)     out_valid_q <= 1'b1;
      else if (out_ready_i)       out_valid_q <= 1'b0;
      if (take) begin
        if (rec_i.last) begin
          crc_q <= CRC_ONES;
          for (int i = 0; i < 4; i++) tail_q[i] <= '0;
        end else begin
          crc_q     <= crc_d;
          tail_q[0] <= tail_q[1];
          tail_q[1] <= tail_q[2];
          tail_q[2] <= tail_q[3];
          tail_q[3] <= rec_i.data;
        end
      end
    end
  end

endmodule

/* sv/ethernet_frame_receive_filter_top.sv */
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] frame byte, tlast end of frame
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: accepted, verdict[1:0], was_broadcast
// cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i: 48-bit station address
//
// One byte per cycle sustained unless the queue fills. The front stage classifies
// each byte against its frame position and the destination address, then writes
// a record into a two-entry queue; the back stage runs the tail window and byte-wide
// CRC. m_axis_tvalid is registered, set when the back stage takes the last byte.
// Reset (async, active low) clears the frame state, queue and station address.
// A stalled output only blocks the back stage at a frame end; bytes keep
// flowing in until the queue fills.
`include "ethernet_frame_receive_filter_top_defines.svh"

module ethernet_frame_receive_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // end_of_frame
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] accepted, [2:1] verdict, [3] was_broadcast, [7:4] zero
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [47:0] cfg_data_i      // station_address
);
  import efrf_pkg::*;

  logic [47:0] station_q;
  logic        push, pop;
  byte_rec_t   front_rec, back_rec;
  fifo_stat_t  fifo_stat;
  logic        back_ready;

  // Config is taken in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          station_q <= '0;
    else if (cfg_valid_i) station_q <= cfg_data_i;
  end

  assign s_axis_tready = !fifo_stat.full;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = !fifo_stat.empty && back_ready;

  efrf_front u_front (
    .clk_i,
    .rst_ni,
    .station_address_i (station_q),
    .push_i            (push),
    .frame_byte_i      (s_axis_tdata),
    .end_of_frame_i    (s_axis_tlast),
    .rec_o             (front_rec)
  );

  efrf_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (front_rec),
    .pop_i   (pop),
    .rdata_o (back_rec),
    .stat_o  (fifo_stat)
  );

  efrf_back u_back (
    .clk_i,
    .rst_ni,
    .rec_valid_i (!fifo_stat.empty),
    .rec_i       (back_rec),
    .rec_ready_o (back_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // accepted flag must agree with the verdict code
  `EFRF_ASSERT_IMPL(a_accept_match, m_axis_tvalid,
                    m_axis_tdata[0] == (m_axis_tdata[2:1] == VERDICT_ACCEPT))
  // queue cannot be full and empty at once
  `EFRF_ASSERT_IMPL(a_fifo_stat, 1'b1, !(fifo_stat.full && fifo_stat.empty))
  // an input transfer into an empty queue leaves it non-empty
  `EFRF_ASSERT_NEXT(a_fifo_fill, push && fifo_stat.empty, !fifo_stat.empty)
  // short frames are never accepted
  `EFRF_ASSERT_IMPL(a_short_reject, m_axis_tvalid && m_axis_tdata[2:1] == VERDICT_SHORT,
                    !m_axis_tdata[0])

endmodule
